// ===== rtl/flux_difference_derivative_defines.svh =====
// assertion macros for the flux difference derivative block
`ifndef FLUX_DIFFERENCE_DERIVATIVE_DEFINES_SVH
`define FLUX_DIFFERENCE_DERIVATIVE_DEFINES_SVH

`ifndef SYNTHESIS
`define FDD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FDD_ASSERT(lbl, clk, rstn, prop, msg)
`define FDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/fdd_pkg.sv =====
// shared types, constants and functions of the flux difference derivative block
`default_nettype none
package fdd_pkg;

  localparam int LANES    = 4;
  localparam int WIN      = 6;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 12;
  localparam int ACC_W    = 45;
  localparam int COEF_W   = 13;
  localparam int MAX_RES  = 3;
  localparam int DIGITS   = 9;

  localparam logic [IDX_W-1:0] LAST_IDX = '1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_INV  = 1'b1;

  localparam logic [63:0] ROUND_BIAS  = 64'd62914560;
  localparam logic [53:0] SAT_POS_LIM = 54'd32212254720;
  localparam logic [53:0] SAT_NEG_LIM = 54'd32212254735;

  typedef enum logic [2:0] {
    C_LEFT1  = 3'd0,
    C_LEFT2  = 3'd1,
    C_INNER  = 3'd2,
    C_RIGHT1 = 3'd3,
    C_RIGHT0 = 3'd4,
    C_TWO    = 3'd5
  } coef_sel_e;

  typedef struct packed {
    coef_sel_e        sel;
    logic [IDX_W-1:0] idx;
    logic             short_line;
    logic             eor;
  } result_desc_t;

  typedef struct packed {
    logic      start;
    coef_sel_e sel;
  } lane_ctrl_t;

  typedef struct packed {
    logic                     done;
    logic                     sat;
    logic signed [DATA_W-1:0] value;
  } lane_res_t;

  typedef struct packed {
    logic         load;
    result_desc_t desc;
  } merge_ctrl_t;

  localparam logic signed [COEF_W-1:0] K_LEFT1 [WIN] =
    '{13'sd0, -13'sd1760, 13'sd1360, 13'sd720, -13'sd400, 13'sd80};
  localparam logic signed [COEF_W-1:0] K_LEFT2 [WIN] =
    '{13'sd0, 13'sd80, -13'sd2160, 13'sd2160, -13'sd80, 13'sd0};
  localparam logic signed [COEF_W-1:0] K_INNER [WIN] =
    '{-13'sd9, 13'sd125, -13'sd2250, 13'sd2250, -13'sd125, 13'sd9};
  localparam logic signed [COEF_W-1:0] K_RIGHT1 [WIN] =
    '{13'sd0, 13'sd0, 13'sd80, -13'sd2160, 13'sd2160, -13'sd80};
  localparam logic signed [COEF_W-1:0] K_RIGHT0 [WIN] =
    '{13'sd0, -13'sd80, 13'sd400, -13'sd720, -13'sd1360, 13'sd1760};
  localparam logic signed [COEF_W-1:0] K_TWO [WIN] =
    '{13'sd0, 13'sd0, 13'sd0, 13'sd0, -13'sd1920, 13'sd1920};

  function automatic logic signed [COEF_W-1:0] coef(coef_sel_e sel, logic [2:0] j);
    logic signed [COEF_W-1:0] c;
    case (sel)
      C_LEFT1:  c = K_LEFT1[j];
      C_LEFT2:  c = K_LEFT2[j];
      C_INNER:  c = K_INNER[j];
      C_RIGHT1: c = K_RIGHT1[j];
      C_RIGHT0: c = K_RIGHT0[j];
      C_TWO:    c = K_TWO[j];
      default:  c = '0;
    endcase
    return c;
  endfunction

  // one hex digit of a divide by 15: returns {quotient digit, remainder}
  function automatic logic [7:0] div15_step(logic [7:0] val);
    logic [15:0] prod;
    logic [3:0]  qd;
    logic [7:0]  r;
    prod = 16'(val) * 16'd137;
    qd   = prod[14:11];
    r    = val - 8'(qd) * 8'd15;
    return {qd, r[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fdd_if.sv =====
// stream interfaces for the flux input and the derivative output
`default_nettype none
interface fdd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_0;
  logic signed [31:0] flux_1;
  logic signed [31:0] flux_2;
  logic signed [31:0] flux_3;
  logic               point_active;
  logic               last_in_line;

  modport source (output valid, flux_0, flux_1, flux_2, flux_3, point_active, last_in_line,
                  input ready);
  modport sink (input valid, flux_0, flux_1, flux_2, flux_3, point_active, last_in_line,
                output ready);
endinterface

interface fdd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] deriv_0;
  logic signed [31:0] deriv_1;
  logic signed [31:0] deriv_2;
  logic signed [31:0] deriv_3;
  logic [11:0]        point_index;
  logic               saturated;
  logic               short_line;
  logic               end_of_run;

  modport source (output valid, deriv_0, deriv_1, deriv_2, deriv_3, point_index, saturated,
                  short_line, end_of_run, input ready);
  modport sink (input valid, deriv_0, deriv_1, deriv_2, deriv_3, point_index, saturated,
                short_line, end_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/flux_difference_derivative.sv =====
// top level of the flux difference derivative block
//
// Takes one half-point flux transfer per grid-line point and returns the negated
// derivative of four variables per point, either as a two-point difference or as a
// sixth-order stencil with one-sided closures, in Q16.16 with rounding and saturation.
// An input transfer is taken only while no earlier point is still being worked on;
// a point that gives no result leaves the input free. Each result runs through four
// identical lanes, one per variable: a multiply-accumulate over the six-point window,
// a 32x32 and a 12x32 multiply by the spacing register, a scale and saturation step
// and a hex-digit division by fifteen, which a lane that clips leaves out. A point
// gives at most three results. The output register lets the next result or the next
// point go ahead while a finished result waits to be taken.
`default_nettype none
`include "flux_difference_derivative_defines.svh"
module flux_difference_derivative (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fdd_in_if.sink      flux_i,
  fdd_out_if.source   deriv_o
);
  import fdd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } top_state_e;

  top_state_e               state_q, state_d;
  logic                     mode_q;
  logic [DATA_W-1:0]        inv_q;
  logic signed [DATA_W-1:0] win_q [WIN][LANES];
  logic                     act_q [WIN];
  logic [IDX_W-1:0]         pos_q;
  result_desc_t             desc_q [MAX_RES];
  result_desc_t             desc_d [MAX_RES];
  logic [1:0]               cnt_q, cnt_d;
  logic [1:0]               slot_q, slot_d;

  logic                     accept;
  logic                     cfg_wr;
  logic                     last;
  logic [IDX_W-1:0]         k;
  logic [1:0]               n;
  logic                     can_load;
  logic                     all_done;
  lane_ctrl_t               lane_ctrl;
  merge_ctrl_t              merge_ctrl;
  lane_res_t                lane_res [LANES];
  logic signed [DATA_W-1:0] lane_win [LANES][WIN];
  logic signed [DATA_W-1:0] flux_in [LANES];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_INV) ? inv_q : {31'b0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      inv_q  <= 32'd65536;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        mode_q <= pwdata[0];
      end else begin
        inv_q <= pwdata;
      end
    end
  end

  assign flux_i.ready = (state_q == ST_IDLE);
  assign accept       = flux_i.valid && flux_i.ready;
  assign flux_in[0]   = flux_i.flux_0;
  assign flux_in[1]   = flux_i.flux_1;
  assign flux_in[2]   = flux_i.flux_2;
  assign flux_in[3]   = flux_i.flux_3;

  assign k    = pos_q;
  assign last = flux_i.last_in_line || (k == LAST_IDX);

  // result list of the point being taken, in output order
  always_comb begin
    for (int s = 0; s < MAX_RES; s++) begin
      desc_d[s] = desc_q[s];
    end
    cnt_d = '0;
    n     = '0;
    if (!mode_q) begin
      if (last && k == '0) begin
        desc_d[0] = '{sel: C_TWO, idx: k, short_line: 1'b1, eor: 1'b1};
        cnt_d     = 2'd1;
      end else if (k != '0 && flux_i.point_active) begin
        desc_d[0] = '{sel: C_TWO, idx: k, short_line: 1'b0, eor: last};
        cnt_d     = 2'd1;
      end
    end else if (last && k < IDX_W'(5)) begin
      desc_d[0] = '{sel: C_TWO, idx: k, short_line: 1'b1, eor: 1'b1};
      cnt_d     = 2'd1;
    end else if (k == IDX_W'(4)) begin
      desc_d[0] = '{sel: C_LEFT1, idx: IDX_W'(1), short_line: 1'b0, eor: 1'b0};
      desc_d[1] = '{sel: C_LEFT2, idx: IDX_W'(2), short_line: 1'b0, eor: 1'b0};
      cnt_d     = 2'd2;
    end else begin
      if (k >= IDX_W'(5) && act_q[4]) begin
        desc_d[0] = '{sel: C_INNER, idx: k - IDX_W'(2), short_line: 1'b0, eor: 1'b0};
        n         = 2'd1;
      end
      if (last) begin
        desc_d[n]         = '{sel: C_RIGHT1, idx: k - IDX_W'(1), short_line: 1'b0, eor: 1'b0};
        desc_d[n + 2'd1]  = '{sel: C_RIGHT0, idx: k, short_line: 1'b0, eor: 1'b1};
        n                 = n + 2'd2;
      end
      cnt_d = n;
    end
  end

  always_comb begin
    state_d          = state_q;
    slot_d           = slot_q;
    lane_ctrl.start  = 1'b0;
    lane_ctrl.sel    = desc_d[0].sel;
    merge_ctrl.load  = 1'b0;
    merge_ctrl.desc  = desc_q[slot_q];
    case (state_q)
      ST_IDLE: begin
        if (accept && cnt_d != '0) begin
          lane_ctrl.start = 1'b1;
          slot_d          = '0;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        lane_ctrl.sel = desc_q[slot_q + 2'd1].sel;
        if (all_done && can_load) begin
          merge_ctrl.load = 1'b1;
          if (slot_q + 2'd1 < cnt_q) begin
            lane_ctrl.start = 1'b1;
            slot_d          = slot_q + 2'd1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      slot_q  <= '0;
      cnt_q   <= '0;
      for (int j = 0; j < WIN; j++) begin
        act_q[j] <= 1'b0;
        for (int l = 0; l < LANES; l++) begin
          win_q[j][l] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (accept) begin
        pos_q <= last ? '0 : k + IDX_W'(1);
        cnt_q <= cnt_d;
        for (int j = 0; j < WIN - 1; j++) begin
          act_q[j] <= act_q[j + 1];
          for (int l = 0; l < LANES; l++) begin
            win_q[j][l] <= win_q[j + 1][l];
          end
        end
        act_q[WIN-1] <= flux_i.point_active;
        for (int l = 0; l < LANES; l++) begin
          win_q[WIN-1][l] <= flux_in[l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int s = 0; s < MAX_RES; s++) begin
        desc_q[s] <= desc_d[s];
      end
    end
  end

  always_comb begin
    all_done = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      all_done = all_done & lane_res[l].done;
      for (int j = 0; j < WIN; j++) begin
        lane_win[l][j] = win_q[j][l];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    fdd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .win_i  (lane_win[l]),
      .inv_i  (inv_q),
      .res_o  (lane_res[l])
    );
  end

  fdd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (merge_ctrl),
    .lane_i     (lane_res),
    .can_load_o (can_load),
    .out        (deriv_o)
  );

  `FDD_ASSERT(a_no_overwrite, clk_i, rst_ni, merge_ctrl.load |-> (!deriv_o.valid || deriv_o.ready), "held result overwritten")
  `FDD_ASSERT(a_short_zero, clk_i, rst_ni, (deriv_o.valid && deriv_o.short_line) |-> (deriv_o.deriv_0 == '0 && !deriv_o.saturated && deriv_o.end_of_run), "short line result not empty")
  `FDD_ASSERT_NEXT(a_load_start, clk_i, rst_ni, lane_ctrl.start, !all_done, "lanes did not restart")

endmodule
`default_nettype wire

// ===== rtl/fdd_lane.sv =====
// one lane: stencil multiply-accumulate, spacing scale, rounding divide and saturation
`default_nettype none
module fdd_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fdd_pkg::lane_ctrl_t              ctrl_i,
  input  logic signed [fdd_pkg::DATA_W-1:0] win_i [fdd_pkg::WIN],
  input  logic [fdd_pkg::DATA_W-1:0]       inv_i,
  output fdd_pkg::lane_res_t               res_o
);
  import fdd_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE  = 5'b00001,
    L_MAC   = 5'b00010,
    L_MUL   = 5'b00100,
    L_SCALE = 5'b01000,
    L_DIV   = 5'b10000
  } lane_state_e;

  lane_state_e              state_q, state_d;
  coef_sel_e                sel_q, sel_d;
  logic [2:0]               j_q, j_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     neg_q, neg_d;
  logic [63:0]              t_q, t_d;
  logic [43:0]              hi_q, hi_d;
  logic [35:0]              pdiv_q, pdiv_d;
  logic [3:0]               rem_q, rem_d;
  logic [31:0]              quo_q, quo_d;
  logic [3:0]               dig_q, dig_d;
  lane_res_t                res_q, res_d;

  logic signed [ACC_W-1:0]  prod;
  logic [ACC_W-1:0]         mag;
  logic [53:0]              psum;
  logic [7:0]               step;
  logic [31:0]              qfin;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    j_d     = j_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    t_d     = t_q;
    hi_d    = hi_q;
    pdiv_d  = pdiv_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dig_d   = dig_q;
    res_d   = res_q;
    prod    = ACC_W'(coef(sel_q, j_q)) * ACC_W'(win_i[j_q]);
    mag     = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    psum    = 54'({hi_q, 9'b0}) + 54'(t_q[63:23]);
    step    = div15_step({rem_q, pdiv_q[35:32]});
    qfin    = {quo_q[27:0], step[7:4]};
    case (state_q)
      L_IDLE: begin
        if (ctrl_i.start) begin
          sel_d      = ctrl_i.sel;
          j_d        = '0;
          acc_d      = '0;
          res_d.done = 1'b0;
          state_d    = L_MAC;
        end
      end
      L_MAC: begin
        acc_d = acc_q + prod;
        j_d   = j_q + 3'd1;
        if (j_q == 3'(WIN - 1)) begin
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        neg_d   = !acc_q[ACC_W-1] && (acc_q != '0);
        t_d     = 64'(mag[31:0]) * 64'(inv_i) + ROUND_BIAS;
        hi_d    = 44'(mag[43:32]) * 44'(inv_i);
        state_d = L_SCALE;
      end
      L_SCALE: begin
        if (neg_q && psum >= SAT_NEG_LIM) begin
          res_d   = '{done: 1'b1, sat: 1'b1, value: 32'sh8000_0000};
          state_d = L_IDLE;
        end else if (!neg_q && psum >= SAT_POS_LIM) begin
          res_d   = '{done: 1'b1, sat: 1'b1, value: 32'sh7FFF_FFFF};
          state_d = L_IDLE;
        end else begin
          pdiv_d  = psum[35:0];
          rem_d   = '0;
          quo_d   = '0;
          dig_d   = '0;
          state_d = L_DIV;
        end
      end
      L_DIV: begin
        quo_d  = qfin;
        rem_d  = step[3:0];
        pdiv_d = {pdiv_q[31:0], 4'b0};
        dig_d  = dig_q + 4'd1;
        if (dig_q == 4'(DIGITS - 1)) begin
          res_d.done  = 1'b1;
          res_d.sat   = 1'b0;
          res_d.value = neg_q ? -$signed(qfin) : $signed(qfin);
          state_d     = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    j_q         <= j_d;
    acc_q       <= acc_d;
    neg_q       <= neg_d;
    t_q         <= t_d;
    hi_q        <= hi_d;
    pdiv_q      <= pdiv_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dig_q       <= dig_d;
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== rtl/fdd_merge.sv =====
// output register that gathers the lane results into one derivative transfer
`default_nettype none
module fdd_merge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fdd_pkg::merge_ctrl_t   ctrl_i,
  input  fdd_pkg::lane_res_t     lane_i [fdd_pkg::LANES],
  output logic                   can_load_o,
  fdd_out_if.source              out
);
  import fdd_pkg::*;

  logic                     valid_q;
  logic signed [DATA_W-1:0] deriv_q [LANES];
  logic [IDX_W-1:0]         idx_q;
  logic                     sat_q;
  logic                     short_q;
  logic                     eor_q;
  logic                     any_sat;

  assign can_load_o = !valid_q || out.ready;

  always_comb begin
    any_sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      any_sat = any_sat | lane_i[l].sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (out.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int l = 0; l < LANES; l++) begin
        deriv_q[l] <= ctrl_i.desc.short_line ? '0 : lane_i[l].value;
      end
      idx_q   <= ctrl_i.desc.idx;
      sat_q   <= !ctrl_i.desc.short_line && any_sat;
      short_q <= ctrl_i.desc.short_line;
      eor_q   <= ctrl_i.desc.eor;
    end
  end

  assign out.valid       = valid_q;
  assign out.deriv_0     = deriv_q[0];
  assign out.deriv_1     = deriv_q[1];
  assign out.deriv_2     = deriv_q[2];
  assign out.deriv_3     = deriv_q[3];
  assign out.point_index = idx_q;
  assign out.saturated   = sat_q;
  assign out.short_line  = short_q;
  assign out.end_of_run  = eor_q;
endmodule
`default_nettype wire

// ===== sim/fdd_derivative_checker.sv =====
// checker for the flux difference derivative block: predicts results and compares transfers
module fdd_derivative_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  fdd_in_if           flux_i,
  fdd_out_if          deriv_o,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fdd_pkg::*;

  typedef struct packed {
    logic signed [31:0] d0;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [31:0] d3;
    logic [11:0]        idx;
    logic               sat;
    logic               short_line;
    logic               eor;
  } deriv_rec_t;

  localparam logic [12:0] MAX_POS = 13'd4095;

  deriv_rec_t expected_derivs[$];
  logic              mode_reg;
  logic [31:0]       spacing_reg;
  logic signed [63:0] flux_win[WIN][LANES];
  logic              act_win[WIN];
  logic [12:0]       line_pos;

  assign pending_count = expected_derivs.size();

  function automatic logic signed [63:0] scale_flux(logic signed [63:0] n, ref logic sat);
    logic        neg_out;
    logic [63:0] mag, ml, mh, t, p, q;
    neg_out = n > 0;
    mag = (n < 0) ? -n : n;
    ml = mag & 64'hFFFF_FFFF;
    mh = mag >> 32;
    t = ml * spacing_reg + 64'd15 * (64'd1 << 22);
    p = ((mh * spacing_reg) << 9) + (t >> 23);
    q = p / 15;
    if (neg_out) begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        sat = 1'b1;
      end
      return -$signed(q);
    end
    if (q > 64'h7FFF_FFFF) begin
      q = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return $signed(q);
  endfunction

  function automatic int weight(coef_sel_e sel, int j);
    int kl1[WIN] = '{0, -1760, 1360, 720, -400, 80};
    int kl2[WIN] = '{0, 80, -2160, 2160, -80, 0};
    int kin[WIN] = '{-9, 125, -2250, 2250, -125, 9};
    int kr1[WIN] = '{0, 0, 80, -2160, 2160, -80};
    int kr0[WIN] = '{0, -80, 400, -720, -1360, 1760};
    int ktw[WIN] = '{0, 0, 0, 0, -1920, 1920};
    case (sel)
      C_LEFT1:  return kl1[j];
      C_LEFT2:  return kl2[j];
      C_INNER:  return kin[j];
      C_RIGHT1: return kr1[j];
      C_RIGHT0: return kr0[j];
      default:  return ktw[j];
    endcase
  endfunction

  task automatic push_deriv(coef_sel_e sel, logic [12:0] idx, logic is_short, logic eor);
    deriv_rec_t r;
    logic signed [31:0] v[LANES];
    logic signed [63:0] n;
    logic sat;
    sat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      v[l] = '0;
      if (!is_short) begin
        n = 0;
        for (int j = 0; j < WIN; j++) n += 64'(weight(sel, j)) * flux_win[j][l];
        v[l] = 32'(scale_flux(n, sat));
      end
    end
    r = '{v[0], v[1], v[2], v[3], idx[11:0], sat, is_short, eor};
    expected_derivs.push_back(r);
  endtask

  task automatic predict_point();
    logic [12:0] k;
    logic last;
    k = line_pos;
    last = flux_i.last_in_line || (k >= MAX_POS);
    for (int j = 0; j < WIN - 1; j++) begin
      flux_win[j] = flux_win[j+1];
      act_win[j] = act_win[j+1];
    end
    flux_win[WIN-1][0] = 64'(flux_i.flux_0);
    flux_win[WIN-1][1] = 64'(flux_i.flux_1);
    flux_win[WIN-1][2] = 64'(flux_i.flux_2);
    flux_win[WIN-1][3] = 64'(flux_i.flux_3);
    act_win[WIN-1] = flux_i.point_active;
    if (!mode_reg) begin
      if (last && k < 1) push_deriv(C_TWO, k, 1'b1, 1'b1);
      else if (k >= 1 && act_win[WIN-1]) push_deriv(C_TWO, k, 1'b0, last);
    end else begin
      if (last && k < 5) push_deriv(C_TWO, k, 1'b1, 1'b1);
      else begin
        if (k == 4) begin
          push_deriv(C_LEFT1, 13'd1, 1'b0, 1'b0);
          push_deriv(C_LEFT2, 13'd2, 1'b0, 1'b0);
        end
        if (k >= 5 && act_win[3]) push_deriv(C_INNER, k - 2, 1'b0, 1'b0);
        if (last) begin
          push_deriv(C_RIGHT1, k - 1, 1'b0, 1'b0);
          push_deriv(C_RIGHT0, k, 1'b0, 1'b1);
        end
      end
    end
    line_pos = last ? 13'd0 : k + 1;
  endtask

  task automatic compare_deriv();
    deriv_rec_t got, want;
    got = '{deriv_o.deriv_0, deriv_o.deriv_1, deriv_o.deriv_2, deriv_o.deriv_3,
            deriv_o.point_index, deriv_o.saturated, deriv_o.short_line, deriv_o.end_of_run};
    result_count++;
    if (expected_derivs.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result transfer %h", $time, got);
      return;
    end
    want = expected_derivs.pop_front();
    if (got.d0 !== want.d0) $display("%0t: deriv_0 exp %0d got %0d", $time, want.d0, got.d0);
    if (got.d1 !== want.d1) $display("%0t: deriv_1 exp %0d got %0d", $time, want.d1, got.d1);
    if (got.d2 !== want.d2) $display("%0t: deriv_2 exp %0d got %0d", $time, want.d2, got.d2);
    if (got.d3 !== want.d3) $display("%0t: deriv_3 exp %0d got %0d", $time, want.d3, got.d3);
    if (got.idx !== want.idx)
      $display("%0t: point_index exp %0d got %0d", $time, want.idx, got.idx);
    if (got.sat !== want.sat)
      $display("%0t: saturated exp %0b got %0b", $time, want.sat, got.sat);
    if (got.short_line !== want.short_line)
      $display("%0t: short_line exp %0b got %0b", $time, want.short_line, got.short_line);
    if (got.eor !== want.eor)
      $display("%0t: end_of_run exp %0b got %0b", $time, want.eor, got.eor);
    if (got !== want) fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_reg = 1'b1;
      spacing_reg = 32'd65536;
      line_pos = '0;
      for (int j = 0; j < WIN; j++) begin
        act_win[j] = 1'b0;
        for (int l = 0; l < LANES; l++) flux_win[j][l] = '0;
      end
      expected_derivs.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (deriv_o.valid && deriv_o.ready) compare_deriv();
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) mode_reg = pwdata[0];
        else spacing_reg = pwdata;
      end
      if (flux_i.valid && flux_i.ready) predict_point();
    end
  end
endmodule

// ===== sim/flux_difference_derivative_tb.sv =====
// testbench top for the flux difference derivative block: stimulus, configuration, verdict
module flux_difference_derivative_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending_count, result_count;
  int          points_sent = 0;
  int          hold_cycles = 0;
  bit          calm = 1'b0;

  fdd_in_if  flux_i ();
  fdd_out_if deriv_o ();

  flux_difference_derivative dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .flux_i(flux_i.sink), .deriv_o(deriv_o.source)
  );

  fdd_derivative_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .flux_i, .deriv_o, .fail_count, .pending_count, .result_count
  );

  always #5 clk_i = ~clk_i;

  initial begin
    flux_i.valid = 1'b0;
    flux_i.flux_0 = '0;
    flux_i.flux_1 = '0;
    flux_i.flux_2 = '0;
    flux_i.flux_3 = '0;
    flux_i.point_active = 1'b0;
    flux_i.last_in_line = 1'b0;
    deriv_o.ready = 1'b0;
  end

  // result side: random stalls, quiet stretches and one long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      deriv_o.ready <= 1'b0;
    end else begin
      deriv_o.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    flux_i.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_flux(int kind);
    case (kind)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(2000)) - 1000) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(logic [31:0] f0, logic [31:0] f1, logic [31:0] f2,
                            logic [31:0] f3, logic act, logic last);
    while (!calm && $urandom_range(99) < 6) begin
      flux_i.valid <= 1'b0;
      @(negedge clk_i);
    end
    flux_i.valid <= 1'b1;
    flux_i.flux_0 <= f0; flux_i.flux_1 <= f1; flux_i.flux_2 <= f2; flux_i.flux_3 <= f3;
    flux_i.point_active <= act; flux_i.last_in_line <= last;
    @(posedge clk_i);
    while (!flux_i.ready) @(posedge clk_i);
    points_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line(int len, int kind, int act_pct);
    for (int i = 0; i < len; i++)
      send_point(rand_flux(kind), rand_flux(kind), rand_flux($urandom_range(3)),
                 rand_flux(3), $urandom_range(99) < act_pct, i == len - 1);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    // sixth-order default: short lines, extremes, normal line
    for (int n = 1; n <= 6; n++) send_line(n, 3, 80);
    send_line(8, 0, 100);
    send_line(8, 1, 0);
    drain();
    write_reg(3'd0, 32'd0);
    write_reg(3'd4, 32'hFFFF_FFFF);
    send_line(1, 3, 100);
    send_line(3, 0, 100);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, '1, '0, 1'b1, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, '0, '1, 1'b1, 1'b1);
    send_line(3, 3, 50);
    drain();
    write_reg(3'd4, 32'd1);
    send_line(6, 3, 100);
    drain();
    write_reg(3'd4, 32'd65536);
    write_reg(3'd0, 32'd1);
    // long hold-off on the result side while points keep coming
    hold_cycles = 300;
    send_line(12, 3, 100);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(3'd0, 32'(ph % 3 != 2));
      write_reg(3'd4, ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 32'd1 : $urandom);
      calm = (ph == 3);
      repeat (8) send_line($urandom_range(4) == 0 ? $urandom_range(1, 6)
                           : $urandom_range(6, 14), $urandom_range(3), 85);
      drain();
    end
    calm = 1'b0;
    $display("covered %0d points, %0d results, both modes, short lines and clipped values",
             points_sent, result_count);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
